/* rtl/d96r_pkg.sv */
// Shared types and constants for the decimal96 round-to-integer block.
package d96r_pkg;

  localparam int MANT_W      = 96;
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = MANT_W / CHUNK_W;
  localparam int CUR_W       = CHUNK_W + 4;
  localparam int PROD_W      = 2 * CUR_W;
  localparam int SCALE_W     = 5;
  localparam int SCALE_LSB   = 16;
  localparam int SIGN_BIT    = 31;
  localparam int RECIP_SHIFT = 23;

  // floor(x * RECIP / 2^23) == x / 10 for every x below 2^22
  localparam logic [CUR_W-1:0] RECIP      = 20'hCCCCD;
  localparam logic [3:0]       HALF_DIGIT = 4'd5;

  localparam logic [1:0] FUNC_ROUND    = 2'd0;
  localparam logic [1:0] FUNC_FLOOR    = 2'd1;
  localparam logic [1:0] FUNC_TRUNCATE = 2'd2;
  localparam logic [1:0] FUNC_TO_INT   = 2'd3;

  typedef struct packed {
    logic load;    // capture a new item
    logic step;    // divide one 16-bit chunk by ten
    logic last;    // this chunk is the lowest one of the word
    logic finish;  // apply rounding and load the output register
  } d96r_cmd_t;

  typedef struct packed {
    logic digits_done;  // no scale left to remove
  } d96r_status_t;

endpackage

/* rtl/d96r_datapath.sv */
// Datapath: mantissa register, chunk-serial divide by ten, rounding and output register.
module d96r_datapath import d96r_pkg::*; #(
  parameter int MAX_SCALE = 28
) (
  input  logic               clk,
  input  d96r_cmd_t          cmd,
  output d96r_status_t       status,
  input  logic [1:0]         func,
  input  logic [31:0]        mant_low,
  input  logic [31:0]        mant_middle,
  input  logic [31:0]        mant_high,
  input  logic [31:0]        flags_word,
  output logic [31:0]        res_low,
  output logic [31:0]        res_middle,
  output logic [31:0]        res_high,
  output logic [31:0]        res_flags,
  output logic signed [31:0] int_value,
  output logic               error_flag
);

  logic [MANT_W-1:0]  mant;
  logic [3:0]         rem;
  logic [3:0]         first;
  logic               sticky;
  logic               neg;
  logic [1:0]         func_q;
  logic [SCALE_W-1:0] scale_left;

  logic [SCALE_W-1:0] scale_in;
  logic [SCALE_W-1:0] scale_clamped;
  logic [CUR_W-1:0]   cur;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [CUR_W-1:0]   quot_x10;
  logic [CUR_W-1:0]   rem_wide;
  logic [3:0]         rem_next;
  logic               inc;
  logic [MANT_W-1:0]  mant_adj;
  logic               too_big;
  logic [31:0]        ival;

  assign scale_in      = flags_word[SCALE_LSB +: SCALE_W];
  assign scale_clamped = (scale_in > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_in;

  // top chunk, with the running remainder above it
  assign cur      = {rem, mant[MANT_W-1 -: CHUNK_W]};
  assign prod     = PROD_W'(cur) * PROD_W'(RECIP);
  assign quot     = prod[RECIP_SHIFT +: CHUNK_W];
  assign quot_x10 = CUR_W'({quot, 3'b000}) + CUR_W'({quot, 1'b0});
  assign rem_wide = cur - quot_x10;
  assign rem_next = rem_wide[3:0];

  always_comb begin
    inc = 1'b0;
    case (func_q)
      FUNC_ROUND:    inc = (first >= HALF_DIGIT);
      FUNC_FLOOR:    inc = neg && sticky;
      FUNC_TRUNCATE: inc = 1'b0;
      default:       inc = 1'b0;
    endcase
  end

  assign mant_adj = inc ? (mant + MANT_W'(1)) : mant;
  assign too_big  = (mant[MANT_W-1:31] != '0);
  assign ival     = neg ? (32'd0 - mant[31:0]) : mant[31:0];

  assign status.digits_done = (scale_left == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mant       <= {mant_high, mant_middle, mant_low};
      rem        <= '0;
      first      <= '0;
      sticky     <= 1'b0;
      neg        <= flags_word[SIGN_BIT];
      func_q     <= func;
      scale_left <= scale_clamped;
    end else if (cmd.step) begin
      // rotate so that after all chunks the word is back in place
      mant <= {mant[MANT_W-CHUNK_W-1:0], quot};
      if (cmd.last) begin
        first      <= rem_next;
        sticky     <= sticky | (rem_next != '0);
        rem        <= '0;
        scale_left <= scale_left - SCALE_W'(1);
      end else begin
        rem <= rem_next;
      end
    end

    if (cmd.finish) begin
      res_low    <= mant_adj[31:0];
      res_middle <= mant_adj[63:32];
      res_high   <= mant_adj[95:64];
      res_flags  <= {neg, 31'd0};
      if (func_q == FUNC_TO_INT) begin
        error_flag <= too_big;
        int_value  <= too_big ? 32'sd0 : signed'(ival);
      end else begin
        error_flag <= 1'b0;
        int_value  <= 32'sd0;
      end
    end
  end

endmodule

/* rtl/d96r_ctrl.sv */
// Controller: sequences load, chunk division steps and the output transfer.
module d96r_ctrl import d96r_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  d96r_status_t status,
  output d96r_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CHUNK_CNT_W-1:0] chunk;
  logic [CHUNK_CNT_W-1:0] chunk_next;
  logic                   out_free;

  assign out_free = !out_valid || out_ready;
  // no input transfer while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    chunk_next = chunk;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          chunk_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.digits_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
          cmd.last = (chunk == CHUNK_CNT_W'(NUM_CHUNKS - 1));
          chunk_next = cmd.last ? '0 : chunk + CHUNK_CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/decimal96_round_to_integer.sv */
// Decimal96 round-to-integer: removes the decimal scale of a 96-bit mantissa
// by repeated division by ten and applies round, floor, truncate or to-int.
// One item at a time: after the input transfer the block divides the 96-bit
// word by ten once for each unit of scale, one 16-bit chunk per cycle through
// a single reciprocal multiplier, then closes and rounds. The result sits in
// an output register, so a new item is taken while the previous result still
// waits for its transfer.
module decimal96_round_to_integer import d96r_pkg::*; #(
  parameter int MAX_SCALE = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [31:0]        mant_low,
  input  logic [31:0]        mant_middle,
  input  logic [31:0]        mant_high,
  input  logic [31:0]        flags_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        res_low,
  output logic [31:0]        res_middle,
  output logic [31:0]        res_high,
  output logic [31:0]        res_flags,
  output logic signed [31:0] int_value,
  output logic               error_flag
);

  d96r_cmd_t    cmd;
  d96r_status_t status;

  d96r_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  d96r_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .mant_low    (mant_low),
    .mant_middle (mant_middle),
    .mant_high   (mant_high),
    .flags_word  (flags_word),
    .res_low     (res_low),
    .res_middle  (res_middle),
    .res_high    (res_high),
    .res_flags   (res_flags),
    .int_value   (int_value),
    .error_flag  (error_flag)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for decimal96_round_to_integer.
module tb_top;
  import d96r_pkg::*;

  localparam int MAX_SCALE   = 28;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 200;  // longer than one item at full scale

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] mant_low;
    logic [31:0] mant_middle;
    logic [31:0] mant_high;
    logic [31:0] flags_word;
  } dec_item_t;

  typedef struct packed {
    logic [31:0]        res_low;
    logic [31:0]        res_middle;
    logic [31:0]        res_high;
    logic [31:0]        res_flags;
    logic signed [31:0] int_value;
    logic               error_flag;
  } int_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = FUNC_ROUND;
  logic [31:0]        mant_low = '0;
  logic [31:0]        mant_middle = '0;
  logic [31:0]        mant_high = '0;
  logic [31:0]        flags_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        res_low;
  logic [31:0]        res_middle;
  logic [31:0]        res_high;
  logic [31:0]        res_flags;
  logic signed [31:0] int_value;
  logic               error_flag;

  int_result_t pending_results[$];
  int          err_count = 0;
  int          results_seen = 0;
  logic        in_gaps_on = 1'b0;
  logic        out_gaps_on = 1'b0;
  int          rx_hold_req = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;

  decimal96_round_to_integer #(.MAX_SCALE(MAX_SCALE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .mant_low(mant_low), .mant_middle(mant_middle),
    .mant_high(mant_high), .flags_word(flags_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_low(res_low), .res_middle(res_middle), .res_high(res_high),
    .res_flags(res_flags), .int_value(int_value), .error_flag(error_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Removes the scale digit by digit, then applies the selected mode.
  function automatic int_result_t round_off_scale(input dec_item_t it);
    int_result_t r;
    logic [95:0] mag;
    logic [3:0]  digit;
    logic        sticky;
    logic        neg;
    int unsigned scale;
    mag    = {it.mant_high, it.mant_middle, it.mant_low};
    neg    = it.flags_word[SIGN_BIT];
    scale  = it.flags_word[SCALE_LSB +: SCALE_W];
    digit  = '0;
    sticky = 1'b0;
    if (scale > MAX_SCALE) scale = MAX_SCALE;
    for (int i = 0; i < scale; i++) begin
      digit  = 4'(mag % 96'd10);
      mag    = mag / 96'd10;
      sticky = sticky | (digit != 0);
    end
    r.int_value  = '0;
    r.error_flag = 1'b0;
    case (it.func)
      FUNC_ROUND: begin
        if (digit >= HALF_DIGIT) mag = mag + 96'd1;
      end
      FUNC_FLOOR: begin
        if (neg && sticky) mag = mag + 96'd1;
      end
      FUNC_TO_INT: begin
        if (mag[95:31] != '0) r.error_flag = 1'b1;
        else r.int_value = neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
      end
      default: ;
    endcase
    r.res_low    = mag[31:0];
    r.res_middle = mag[63:32];
    r.res_high   = mag[95:64];
    r.res_flags  = {neg, 31'd0};
    return r;
  endfunction

  function automatic logic [31:0] flags_of(input logic neg, input int unsigned scale);
    return {neg, 10'd0, 5'(scale), 16'd0};
  endfunction

  function automatic dec_item_t mk(input logic [1:0] f, input logic [95:0] mag,
                                   input logic [31:0] fl);
    dec_item_t it;
    it.func        = f;
    it.mant_low    = mag[31:0];
    it.mant_middle = mag[63:32];
    it.mant_high   = mag[95:64];
    it.flags_word  = fl;
    return it;
  endfunction

  // Mostly short scales to keep the run fast; the clamped range still shows up.
  function automatic int unsigned pick_scale();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 85) return $urandom_range(7, 18);
    return $urandom_range(19, 31);
  endfunction

  function automatic dec_item_t random_item();
    logic [95:0] mag;
    logic [31:0] fl;
    int unsigned r;
    r   = $urandom_range(99);
    mag = {$urandom, $urandom, $urandom};
    if (r < 30) mag = {64'd0, $urandom};
    else if (r < 60) mag = mag >> $urandom_range(95);
    fl = $urandom;
    fl[SCALE_LSB +: SCALE_W] = 5'(pick_scale());
    return mk(2'($urandom_range(3)), mag, fl);
  endfunction

  // Magnitude after scaling lands within a few units of 2^31.
  function automatic dec_item_t near_int_limit();
    logic [127:0] p10;
    logic [127:0] m;
    logic [31:0]  base;
    logic [31:0]  fl;
    int unsigned  sc;
    sc  = $urandom_range(0, 19);
    p10 = 128'd1;
    for (int i = 0; i < sc; i++) p10 = p10 * 128'd10;
    base = 32'h8000_0000 + $urandom_range(0, 6) - 32'd3;
    m    = base * p10 + ({$urandom, $urandom} % p10);
    fl   = $urandom;
    fl[SCALE_LSB +: SCALE_W] = 5'(sc);
    return mk(($urandom_range(3) == 0) ? 2'($urandom_range(3)) : FUNC_TO_INT,
              m[95:0], fl);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_item(input dec_item_t it);
    if (in_gaps_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= it.func;
    mant_low    <= it.mant_low;
    mant_middle <= it.mant_middle;
    mant_high   <= it.mant_high;
    flags_word  <= it.flags_word;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(round_off_scale(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver side: ready pattern and result checks.
  always @(posedge clk) begin
    int_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d with no transfer pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (res_low !== want.res_low)
          report_error($sformatf("res_low got %h want %h", res_low, want.res_low));
        if (res_middle !== want.res_middle)
          report_error($sformatf("res_middle got %h want %h", res_middle, want.res_middle));
        if (res_high !== want.res_high)
          report_error($sformatf("res_high got %h want %h", res_high, want.res_high));
        if (res_flags !== want.res_flags)
          report_error($sformatf("res_flags got %h want %h", res_flags, want.res_flags));
        if (int_value !== want.int_value)
          report_error($sformatf("int_value got %0d want %0d", int_value, want.int_value));
        if (error_flag !== want.error_flag)
          report_error($sformatf("error_flag got %b want %b", error_flag, want.error_flag));
      end
    end
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (out_gaps_on && $urandom_range(99) < 25) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_directed();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    for (int f = 0; f < 4; f++) send_item(mk(2'(f), {96{1'b1}}, flags_of(1'b0, 0)));
    for (int f = 0; f < 4; f++) send_item(mk(2'(f), {96{1'b1}}, flags_of(1'b1, 28)));
    // scale field above the clamp, every ignored flag bit set
    send_item(mk(FUNC_FLOOR, 96'd123456789, 32'hFFFF_FFFF));
    send_item(mk(FUNC_ROUND, 96'd25, flags_of(1'b0, 1)));
    send_item(mk(FUNC_ROUND, 96'd24, flags_of(1'b0, 1)));
    send_item(mk(FUNC_ROUND, 96'd15, flags_of(1'b1, 1)));
    // floor: nonzero digit below a zero first digit
    send_item(mk(FUNC_FLOOR, 96'd1001, flags_of(1'b1, 2)));
    send_item(mk(FUNC_FLOOR, 96'd1001, flags_of(1'b0, 2)));
    send_item(mk(FUNC_FLOOR, 96'd1000, flags_of(1'b1, 2)));
    send_item(mk(FUNC_TRUNCATE, 96'd999, flags_of(1'b0, 2)));
    // scale beyond the digits of the mantissa
    send_item(mk(FUNC_ROUND, 96'd5, flags_of(1'b0, 28)));
    send_item(mk(FUNC_FLOOR, 96'd5, flags_of(1'b1, 28)));
    send_item(mk(FUNC_TO_INT, 96'h7FFF_FFFF, flags_of(1'b0, 0)));
    send_item(mk(FUNC_TO_INT, 96'h8000_0000, flags_of(1'b1, 0)));
    send_item(mk(FUNC_TO_INT, 96'h7FFF_FFFF, flags_of(1'b1, 0)));
    send_item(mk(FUNC_TO_INT, 96'd0, flags_of(1'b1, 0)));
    send_item(mk(FUNC_TO_INT, 96'd21474836479, flags_of(1'b0, 1)));
    send_item(mk(FUNC_TO_INT, 96'h1_0000_0000, flags_of(1'b0, 0)));
    wait_drained();
  endtask

  task automatic test_random_mixed();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    for (int i = 0; i < 500; i++) begin
      send_item(random_item());
      if (i == 250) wait_drained();  // sender pause with everything delivered
    end
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    for (int i = 0; i < 200; i++) send_item(random_item());
    wait_drained();
  endtask

  // Receiver stops for a long stretch; the block fills and stalls its input.
  task automatic test_output_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    rx_hold_req = rx_hold_req + 1;
    for (int i = 0; i < 30; i++)
      send_item(mk(2'($urandom_range(3)), {$urandom, $urandom, $urandom},
                   flags_of(1'($urandom_range(1)), $urandom_range(0, 3))));
    wait_drained();
  endtask

  task automatic test_to_int_bounds();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    for (int i = 0; i < 200; i++) send_item(near_int_limit());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mixed();
    test_random_no_idle();
    test_output_backpressure();
    test_to_int_bounds();
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
